FILE: src/gsu_pkg.sv
// ----------------------------------------------------------------------------
// gsu_pkg - shared types and helpers for the GSM septet unpacker
// Queue entry layout, handshake status groups and hex character decoding.
// ----------------------------------------------------------------------------
package gsu_pkg;

	localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
	localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
	localparam logic [7:0] CHAR_A    = 8'h41;  // 'A'
	localparam logic [7:0] CHAR_F    = 8'h46;  // 'F'
	localparam logic [7:0] NIBBLE_A  = 8'd10;  // value of hex digit A
	localparam int         LAST_SHIFT = 6;     // seventh octet of a group

	// One octet's septets: sep0 always, sep1 on a seventh octet short of the count
	typedef struct packed {
		logic       two;
		logic [6:0] sep0;
		logic       done0;
		logic [6:0] sep1;
		logic       done1;
	} queue_entry_t;

	typedef struct packed {
		logic         valid;
		queue_entry_t entry;
	} queue_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Decode one ASCII hex digit (0-9, A-F); anything else counts as zero
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			v = c - CHAR_ZERO;
		end else if (c >= CHAR_A && c <= CHAR_F) begin
			v = c - CHAR_A + NIBBLE_A;
		end
		return v[3:0];
	endfunction

endpackage

FILE: src/gsu_in_if.sv
// ----------------------------------------------------------------------------
// gsu_in_if - hex pair channel
// One beat carries one octet as two ASCII hex characters plus message start.
// ----------------------------------------------------------------------------
interface gsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] hex_high;
	logic [7:0] hex_low;
	logic       start_req;
	logic [7:0] septet_total;

	modport source (output valid, output hex_high, output hex_low, output start_req,
		output septet_total, input ready);
	modport sink (input valid, input hex_high, input hex_low, input start_req,
		input septet_total, output ready);
endinterface

FILE: src/gsu_out_if.sv
// ----------------------------------------------------------------------------
// gsu_out_if - septet channel
// One beat carries one 7-bit character with its end flags.
// ----------------------------------------------------------------------------
interface gsu_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] septet;
	logic       last;
	logic       message_done;

	modport source (output valid, output septet, output last, output message_done,
		input ready);
	modport sink (input valid, input septet, input last, input message_done,
		output ready);
endinterface

FILE: src/gsu_front.sv
// ----------------------------------------------------------------------------
// gsu_front - octet decode and shift state
// Accepts hex pairs, tracks shift position and count, queues the septets.
// ----------------------------------------------------------------------------
module gsu_front #(
	parameter int COUNT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gsu_in_if.sink               octets,
	input  gsu_pkg::queue_status_t status,
	output gsu_pkg::queue_push_t push
);
	import gsu_pkg::*;

	logic [7:0]            prev_q;
	logic [2:0]            shift_q;
	logic [COUNT_BITS-1:0] out_q;
	logic [COUNT_BITS-1:0] wanted_q;

	logic [7:0]            eff_prev;
	logic [2:0]            eff_shift;
	logic [COUNT_BITS-1:0] eff_out;
	logic [COUNT_BITS-1:0] eff_wanted;
	logic [COUNT_BITS-1:0] cnt1;
	logic [COUNT_BITS-1:0] cnt2;
	logic [7:0]            octet;
	logic [2:0]            m;
	logic [15:0]           pair;
	logic [3:0]            sh;
	logic                  active;
	logic                  accept;
	logic                  done0;
	logic                  two;

	assign octets.ready = !status.full;
	assign accept       = octets.valid && octets.ready;

	always_comb begin
		eff_prev   = octets.start_req ? 8'd0 : prev_q;
		eff_shift  = octets.start_req ? 3'd0 : shift_q;
		eff_out    = octets.start_req ? '0 : out_q;
		eff_wanted = octets.start_req ? COUNT_BITS'(octets.septet_total) : wanted_q;
		active     = eff_out < eff_wanted;
		octet      = {hex_nibble(octets.hex_high), hex_nibble(octets.hex_low)};
		m          = (eff_shift > 3'(LAST_SHIFT)) ? 3'(LAST_SHIFT) : eff_shift;
		// octet above prev; shift right by 8-m leaves the merged septet in the low bits
		pair       = {octet, eff_prev};
		sh         = 4'd8 - {1'b0, m};
		cnt1       = eff_out + COUNT_BITS'(1);
		cnt2       = eff_out + COUNT_BITS'(2);
		done0      = cnt1 == eff_wanted;
		two        = (m == 3'(LAST_SHIFT)) && !done0;

		push.valid       = accept && active;
		push.entry.two   = two;
		push.entry.sep0  = 7'(pair >> sh);
		push.entry.done0 = done0;
		push.entry.sep1  = octet[7:1];
		push.entry.done1 = cnt2 == eff_wanted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 8'd0;
			shift_q  <= 3'd0;
			out_q    <= '0;
			wanted_q <= '0;
		end else if (accept) begin
			wanted_q <= eff_wanted;
			if (active) begin
				prev_q  <= octet;
				shift_q <= (m == 3'(LAST_SHIFT)) ? 3'd0 : m + 3'd1;
				out_q   <= two ? cnt2 : cnt1;
			end else begin
				prev_q  <= eff_prev;
				shift_q <= eff_shift;
				out_q   <= eff_out;
			end
		end
	end

endmodule

FILE: src/gsu_queue.sv
// ----------------------------------------------------------------------------
// gsu_queue - two-entry queue between front and back
// Holds decoded octet results so each side can stall on its own.
// ----------------------------------------------------------------------------
module gsu_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gsu_pkg::queue_push_t   push,
	input  logic                   pop,
	output gsu_pkg::queue_status_t status,
	output gsu_pkg::queue_entry_t  head
);
	import gsu_pkg::*;

	queue_entry_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign status.full  = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;
	assign do_push      = push.valid && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/gsu_back.sv
// ----------------------------------------------------------------------------
// gsu_back - septet emitter
// Drives one or two septet beats per queue entry, then pops it.
// ----------------------------------------------------------------------------
module gsu_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gsu_pkg::queue_status_t status,
	input  gsu_pkg::queue_entry_t  head,
	output logic                   pop,
	gsu_out_if.source              septets
);
	import gsu_pkg::*;

	logic sub_q;  // 1 while the second septet of the head entry is due
	logic beat;

	assign septets.valid        = !status.empty;
	assign septets.septet       = sub_q ? head.sep1 : head.sep0;
	assign septets.last         = sub_q || !head.two;
	assign septets.message_done = sub_q ? head.done1 : head.done0;
	assign beat                 = septets.valid && septets.ready;
	assign pop                  = beat && septets.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (beat) begin
			sub_q <= !septets.last;
		end
	end

endmodule

FILE: src/gsm_septet_unpacker.sv
// ----------------------------------------------------------------------------
// gsm_septet_unpacker - GSM 7-bit default alphabet unpacking
// Turns hex-encoded SMS user data into septets, stopping at the message count.
// ----------------------------------------------------------------------------
// A septet is registered in the queue and offered when its entry is the head.
// Throughput: one octet beat per cycle while the queue has room, but the
// seventh octet of a group gives two beats on the single output port, so
// the two-entry queue fills and holds the input back, as do output stalls.
// Reset: arst_n clears shift state, counts, queue and emitter at once.
// ----------------------------------------------------------------------------
module gsm_septet_unpacker #(
	parameter int COUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	gsu_in_if.sink     octets,
	gsu_out_if.source  septets
);
	import gsu_pkg::*;

	queue_push_t   push;
	queue_status_t status;
	queue_entry_t  head;
	logic          pop;

	// Front: decode hex pair, merge with the previous octet, advance counts
	gsu_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.octets (octets),
		.status (status),
		.push   (push)
	);

	// Queue: decouple octet intake from septet delivery
	gsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.status (status),
		.head   (head)
	);

	// Back: deliver one or two beats per entry
	gsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.status  (status),
		.head    (head),
		.pop     (pop),
		.septets (septets)
	);

	// The front must never offer an entry the queue cannot hold
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && status.full))
		else $error("push while queue full");

	// A non-final beat is always followed by the second septet of the octet
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(septets.valid && septets.ready && !septets.last) |=> septets.valid)
		else $error("second septet missing");

	// The final septet of a message ends its octet's beats
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(septets.valid && septets.message_done) |-> septets.last)
		else $error("message end on a non-final beat");

endmodule

FILE: bench/gsu_septet_checker.sv
// ----------------------------------------------------------------------------
// gsu_septet_checker - septet predictor and comparator
// Watches both channels, predicts the septet beats of every accepted octet
// beat and compares each accepted septet beat with the oldest prediction.
// ----------------------------------------------------------------------------
module gsu_septet_checker (
	input  logic clk,
	input  logic arst_n,
	gsu_in_if    octets,
	gsu_out_if   septets,
	output int   fail_count,
	output int   pending,
	output int   septets_checked
);

	typedef struct packed {
		logic [6:0] septet;
		logic       last;
		logic       message_done;
	} septet_beat_t;

	septet_beat_t expected_septets[$];

	logic [7:0] prev_octet;
	logic [2:0] shift_pos;
	logic [7:0] septets_sent;
	logic [7:0] septets_wanted;

	// '0'..'9' and 'A'..'F' carry their value in the low nibble (letters off by 9)
	function automatic logic [3:0] char_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return c[3:0];
		end
		if (c >= "A" && c <= "F") begin
			return c[3:0] + 4'd9;
		end
		return 4'd0;
	endfunction

	task automatic unpack_octet(input logic [7:0] hh, input logic [7:0] hl, input logic st,
		input logic [7:0] tot);
		logic [7:0]   octet;
		logic [2:0]   m;
		septet_beat_t first;
		septet_beat_t second;
		if (st) begin
			prev_octet     = '0;
			shift_pos      = '0;
			septets_sent   = '0;
			septets_wanted = tot;
		end
		if (septets_sent >= septets_wanted) begin
			return;
		end
		octet = {char_value(hh), char_value(hl)};
		m = (shift_pos > 3'd6) ? 3'd6 : shift_pos;
		first.septet = (m == 3'd0) ? octet[6:0] : 7'((octet << m) | (prev_octet >> (8 - m)));
		septets_sent = septets_sent + 8'd1;
		first.last = 1'b1;
		first.message_done = (septets_sent == septets_wanted);
		if (m == 3'd6) begin
			// seventh octet: its upper seven bits form a second septet unless the count is met
			if (septets_sent < septets_wanted) begin
				first.last = 1'b0;
				expected_septets.push_back(first);
				septets_sent = septets_sent + 8'd1;
				second.septet = octet[7:1];
				second.last = 1'b1;
				second.message_done = (septets_sent == septets_wanted);
				expected_septets.push_back(second);
			end else begin
				expected_septets.push_back(first);
			end
			shift_pos = 3'd0;
		end else begin
			expected_septets.push_back(first);
			shift_pos = m + 3'd1;
		end
		prev_octet = octet;
	endtask

	task automatic check_septet();
		septet_beat_t want;
		if (expected_septets.size() == 0) begin
			$error("unexpected septet beat: septet %02h last %0b message_done %0b",
				septets.septet, septets.last, septets.message_done);
			fail_count++;
		end else begin
			want = expected_septets.pop_front();
			if (septets.septet !== want.septet) begin
				$error("septet: expected %02h, actual %02h", want.septet, septets.septet);
				fail_count++;
			end
			if (septets.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, septets.last);
				fail_count++;
			end
			if (septets.message_done !== want.message_done) begin
				$error("message_done: expected %0b, actual %0b", want.message_done,
					septets.message_done);
				fail_count++;
			end
			septets_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_octet      = '0;
			shift_pos       = '0;
			septets_sent    = '0;
			septets_wanted  = '0;
			fail_count      = 0;
			septets_checked = 0;
			expected_septets.delete();
		end else begin
			if (octets.valid && octets.ready) begin
				unpack_octet(octets.hex_high, octets.hex_low, octets.start_req,
					octets.septet_total);
			end
			if (septets.valid && septets.ready) begin
				check_septet();
			end
		end
		pending = expected_septets.size();
	end

endmodule

FILE: bench/tb_gsm_septet_unpacker.sv
// ----------------------------------------------------------------------------
// tb_gsm_septet_unpacker - regression for the GSM septet unpacker
// Drives hex pair beats (directed corner cases, then random messages with
// noise and early restarts) under random stalls on both channels; the
// checker beside the block predicts and compares every septet beat.
// ----------------------------------------------------------------------------
module tb_gsm_septet_unpacker;
	import gsu_pkg::*;

	localparam int RANDOM_BEATS = 1600;

	logic clk;
	logic arst_n;
	bit   calm;        // no idling on either side while set
	bit   paused;
	int   fails;
	int   pending;
	int   septets_checked;
	int   octet_beats;
	int   messages;

	gsu_in_if  octets_if ();
	gsu_out_if septets_if ();

	gsm_septet_unpacker #(
		.COUNT_BITS(8)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.octets (octets_if),
		.septets(septets_if)
	);

	gsu_septet_checker watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.octets         (octets_if),
		.septets        (septets_if),
		.fail_count     (fails),
		.pending        (pending),
		.septets_checked(septets_checked)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Septet side: drop ready at random, 31 percent of the time, except in the calm stretch
	always @(posedge clk) begin
		septets_if.ready <= calm || ($urandom_range(99) >= 31);
	end

	// Mostly legal upper-case hex digits; now and then any byte at all
	function automatic logic [7:0] pick_char();
		logic [3:0] d;
		if ($urandom_range(99) < 12) begin
			return 8'($urandom_range(255));
		end
		d = 4'($urandom_range(15));
		return (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d) - 8'd10;
	endfunction

	// Offer one octet beat after a random number of idle cycles and hold it
	// until it is taken. Ready is sampled at the falling edge, where it has
	// settled, and the beat counts as taken at the following rising edge.
	task automatic push_octet(input logic [7:0] hh, input logic [7:0] hl, input logic st,
		input logic [7:0] tot);
		bit took;
		while (!calm && $urandom_range(99) < 31) begin
			octets_if.valid <= 1'b0;
			@(posedge clk);
		end
		octets_if.valid        <= 1'b1;
		octets_if.hex_high     <= hh;
		octets_if.hex_low      <= hl;
		octets_if.start_req    <= st;
		octets_if.septet_total <= tot;
		do begin
			@(negedge clk);
			took = octets_if.ready;
			@(posedge clk);
		end while (!took);
		octet_beats++;
	endtask

	// Send a message header beat plus payload; the total rides on the first beat only
	task automatic send_message(input logic [7:0] total, input int beats);
		for (int i = 0; i < beats; i++) begin
			push_octet(pick_char(), pick_char(), i == 0,
				(i == 0) ? total : 8'($urandom_range(255)));
		end
		messages++;
	endtask

	// Hold the sender until every predicted septet has been seen, then let the block settle
	task automatic drain();
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [7:0] total;
		int         beats;
		int         extra;
		int         roll;

		octets_if.valid        = 1'b0;
		octets_if.hex_high     = '0;
		octets_if.hex_low      = '0;
		octets_if.start_req    = 1'b0;
		octets_if.septet_total = '0;
		septets_if.ready       = 1'b0;
		calm     = 1'b0;
		paused   = 1'b0;
		messages = 0;
		octet_beats = 0;
		arst_n   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero total: the start beat gives nothing, and the next beat finds the
		// message already complete
		push_octet("1", "2", 1'b1, 8'd0);
		push_octet("3", "4", 1'b0, 8'hFF);

		// Full group of seven octets with eight septets: walk every shift
		// position, digit extremes, lower case and the characters just outside
		// both digit ranges (all of which decode as zero)
		push_octet("0", "0", 1'b1, 8'd8);
		push_octet("F", "F", 1'b0, 8'd0);
		push_octet("9", "A", 1'b0, 8'd0);
		push_octet("a", "f", 1'b0, 8'd0);
		push_octet(8'h2F, 8'h3A, 1'b0, 8'd0);
		push_octet(8'h40, 8'h47, 1'b0, 8'd0);
		push_octet(8'hFF, 8'h00, 1'b0, 8'd0);
		messages++;

		// Seven septets: the count is met by the first septet of the seventh
		// octet, so its second septet is dropped; then one overrun beat
		for (int i = 0; i < 6; i++) begin
			push_octet((i == 0) ? "F" : "A", "5", i == 0, 8'd7);
		end
		push_octet("F", "F", 1'b0, 8'd0);
		push_octet("1", "1", 1'b0, 8'd0);
		messages++;

		// Largest total, cut short by a fresh start mid-message
		push_octet("F", "F", 1'b1, 8'd255);
		push_octet("0", "1", 1'b0, 8'd0);
		push_octet("C", "3", 1'b1, 8'd1);
		messages += 2;

		// Random messages, mostly well formed
		while (octet_beats < RANDOM_BEATS) begin
			calm = (octet_beats >= 300 && octet_beats < 700);
			if (!paused && octet_beats >= 900) begin
				paused = 1'b1;
				octets_if.valid <= 1'b0;
				drain();
			end
			roll = $urandom_range(99);
			if (roll < 80) begin
				total = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 41))
					: 8'($urandom_range(40, 1));
				beats = (int'(total) * 7 + 7) / 8;
				// now and then cut the message short; the next start restarts it
				if ($urandom_range(9) == 0) begin
					beats = $urandom_range(beats, 1);
				end
				send_message(total, beats);
				extra = ($urandom_range(4) == 0) ? $urandom_range(2, 1) : 0;
				for (int i = 0; i < extra; i++) begin
					push_octet(pick_char(), pick_char(), 1'b0, 8'($urandom_range(255)));
				end
			end else begin
				push_octet(8'($urandom_range(255)), 8'($urandom_range(255)),
					$urandom_range(3) == 0, 8'($urandom_range(255)));
			end
		end
		calm = 1'b0;

		octets_if.valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		@(negedge clk);

		$display("covered %0d messages in %0d octet beats, %0d septet beats compared",
			messages, octet_beats, septets_checked);
		$display("corner cases: zero total, overrun beats, non-hex characters, early restarts");
		if (fails == 0 && pending == 0) begin
			$display("gsm_septet_unpacker regression: pass");
		end else begin
			$display("gsm_septet_unpacker regression: fail");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("gsm_septet_unpacker regression: fail");
		$finish;
	end

endmodule
